### hdl/lps_pkg.sv
// Shared constants, types and field widths for the line pixel stepper.
`timescale 1ns / 1ps

package lps_pkg;

    localparam int COORD_W = 12;
    localparam int DEPTH_W = 32;
    localparam int RGB_W = 24;
    localparam int DIST_W = COORD_W + 1;
    localparam int ERR_W = COORD_W + 4;

    localparam int IN_FIELDS_W = 4 * COORD_W + 2 * DEPTH_W + RGB_W;
    localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * COORD_W + DEPTH_W + RGB_W;
    localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_NEXT = 1'b1;

    typedef struct packed {
        logic                       active;
        logic signed [COORD_W-1:0]  cur_x;
        logic signed [COORD_W-1:0]  cur_y;
        logic signed [ERR_W-1:0]    err;
        logic [DIST_W-1:0]          steps;
        logic signed [COORD_W-1:0]  tgt_x;
        logic signed [COORD_W-1:0]  tgt_y;
        logic [DEPTH_W-1:0]         depth;
        logic [RGB_W-1:0]           rgb;
        logic                       is_wide;
        logic                       is_rising;
        logic signed [ERR_W-1:0]    inc_diag;
        logic signed [ERR_W-1:0]    inc_straight;
    } line_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [DEPTH_W-1:0]         z;
        logic [RGB_W-1:0]           rgb;
    } pixel_t;

endpackage

### hdl/lps_setup.sv
// Line setup: orders the endpoints and derives the octant, step count and error terms.
`timescale 1ns / 1ps

module lps_setup (
    input  logic signed [lps_pkg::COORD_W-1:0] x_start,
    input  logic signed [lps_pkg::COORD_W-1:0] y_start,
    input  logic [lps_pkg::DEPTH_W-1:0]        z_start,
    input  logic signed [lps_pkg::COORD_W-1:0] x_end,
    input  logic signed [lps_pkg::COORD_W-1:0] y_end,
    input  logic [lps_pkg::DEPTH_W-1:0]        z_end,
    input  logic [lps_pkg::RGB_W-1:0]          line_rgb,
    output lps_pkg::line_state_t               init_state
);

    logic                               swap;
    logic signed [lps_pkg::COORD_W-1:0] xa;
    logic signed [lps_pkg::COORD_W-1:0] ya;
    logic signed [lps_pkg::COORD_W-1:0] xb;
    logic signed [lps_pkg::COORD_W-1:0] yb;
    logic signed [lps_pkg::DIST_W-1:0]  dx;
    logic signed [lps_pkg::DIST_W-1:0]  dy;
    logic signed [lps_pkg::DIST_W-1:0]  ady;
    logic signed [lps_pkg::ERR_W-1:0]   dx_e;
    logic signed [lps_pkg::ERR_W-1:0]   dy_e;
    logic signed [lps_pkg::ERR_W-1:0]   dx2;
    logic signed [lps_pkg::ERR_W-1:0]   dy2;
    logic                               rising;
    logic                               wide;

    assign swap = x_start > x_end;
    assign xa = swap ? x_end : x_start;
    assign ya = swap ? y_end : y_start;
    assign xb = swap ? x_start : x_end;
    assign yb = swap ? y_start : y_end;

    assign dx = lps_pkg::DIST_W'(xb) - lps_pkg::DIST_W'(xa);
    assign dy = lps_pkg::DIST_W'(yb) - lps_pkg::DIST_W'(ya);
    assign ady = dy[lps_pkg::DIST_W-1] ? -dy : dy;
    assign rising = !dy[lps_pkg::DIST_W-1] && (dy != '0);
    assign wide = dx >= ady;

    assign dx_e = lps_pkg::ERR_W'(dx);
    assign dy_e = lps_pkg::ERR_W'(dy);
    assign dx2 = dx_e <<< 1;
    assign dy2 = dy_e <<< 1;

    always_comb begin
        init_state.active = 1'b1;
        init_state.cur_x = xa;
        init_state.cur_y = ya;
        init_state.tgt_x = xb;
        init_state.tgt_y = yb;
        init_state.depth = swap ? z_end : z_start;
        init_state.rgb = line_rgb;
        init_state.is_wide = wide;
        init_state.is_rising = rising;
        init_state.inc_diag = rising ? (dy2 - dx2) : (dy2 + dx2);
        if (wide) begin
            init_state.steps = dx;
            init_state.inc_straight = dy2;
            init_state.err = rising ? (dy2 - dx_e) : (dy2 + dx_e);
        end else begin
            init_state.steps = ady;
            init_state.inc_straight = rising ? -dx2 : dx2;
            init_state.err = rising ? (dy_e - dx2) : (dy_e + dx2);
        end
    end

endmodule

### hdl/lps_step.sv
// Pixel step: emits the current pixel and, unless it is the end point, advances the midpoint error by one move.
`timescale 1ns / 1ps

module lps_step (
    input  lps_pkg::line_state_t cur_state,
    output lps_pkg::pixel_t      pixel,
    output logic                 last,
    output lps_pkg::line_state_t next_state
);

    logic err_pos;
    logic err_neg;
    logic diag;
    logic move_x;
    logic move_y;
    logic signed [lps_pkg::COORD_W-1:0] y_step;

    assign err_neg = cur_state.err[lps_pkg::ERR_W-1];
    assign err_pos = !err_neg && (cur_state.err != '0);
    assign diag = (cur_state.is_wide == cur_state.is_rising) ? err_pos : err_neg;
    assign move_x = diag || cur_state.is_wide;
    assign move_y = diag || !cur_state.is_wide;
    assign y_step = cur_state.is_rising ? lps_pkg::COORD_W'(1) : '1;
    assign last = (cur_state.steps == '0);

    always_comb begin
        pixel.z = cur_state.depth;
        pixel.rgb = cur_state.rgb;
        next_state = cur_state;
        if (last) begin
            pixel.x = cur_state.tgt_x;
            pixel.y = cur_state.tgt_y;
            next_state.active = 1'b0;
        end else begin
            pixel.x = cur_state.cur_x;
            pixel.y = cur_state.cur_y;
            if (move_x) begin
                next_state.cur_x = cur_state.cur_x + lps_pkg::COORD_W'(1);
            end
            if (move_y) begin
                next_state.cur_y = cur_state.cur_y + y_step;
            end
            next_state.err = cur_state.err
                + (diag ? cur_state.inc_diag : cur_state.inc_straight);
            next_state.steps = cur_state.steps - lps_pkg::DIST_W'(1);
        end
    end

endmodule

### hdl/line_pixel_stepper_top.sv
// Top level of the line pixel stepper: input register, line state and result register.
//
// The s_ channel carries one command per transaction. s_tuser is the mode: a start
// transaction loads two endpoints, a depth and a color from s_tdata and yields the
// first pixel; a next transaction yields the following pixel of the active line.
// Every accepted transaction gives exactly one result transaction on the m_ channel.
// m_tuser is high when a pixel is produced and low when a next transaction found no
// active line (then m_tdata and m_tlast are zero). m_tlast marks the end point.
// The pixel depth is the depth of the left endpoint, held for the whole line.
// A command passes through the input register and then the result register before m_tvalid
// rises; the result register loads only when it is empty or being read. One add and compare per
// command, so one command is taken every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transaction and the input
// register still takes one more command; s_tready falls only when both are full.
// Reset (aresetn low, synchronous) empties both registers and drops any active line.
`timescale 1ns / 1ps

module line_pixel_stepper_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: x_start, y_start, z_start, x_end, y_end, z_end, line_rgb.
    input  logic [lps_pkg::IN_DATA_W-1:0]   s_tdata,
    // Fields from bit 0: mode.
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: pixel_x, pixel_y, pixel_z, pixel_rgb.
    output logic [lps_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Fields from bit 0: valid_res.
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int CW = lps_pkg::COORD_W;
    localparam int DW = lps_pkg::DEPTH_W;

    logic                                in_valid_reg;
    logic                                in_mode_reg;
    logic [lps_pkg::IN_FIELDS_W-1:0]     in_data_reg;
    logic                                out_valid_reg;
    logic                                out_res_reg;
    logic                                out_last_reg;
    lps_pkg::pixel_t                     out_pixel_reg;
    lps_pkg::line_state_t                state_reg;
    lps_pkg::line_state_t                state_next;

    logic                                out_load;
    logic                                work;
    lps_pkg::line_state_t                init_state;
    lps_pkg::line_state_t                base_state;
    lps_pkg::line_state_t                stepped_state;
    lps_pkg::pixel_t                     step_pixel;
    logic                                step_last;
    logic                                produce;
    lps_pkg::pixel_t                     res_pixel;
    logic                                res_last;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign work = in_valid_reg && out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tuser;
            in_data_reg <= s_tdata[lps_pkg::IN_FIELDS_W-1:0];
        end
    end

    lps_setup u_setup (
        .x_start    (in_data_reg[CW-1:0]),
        .y_start    (in_data_reg[2*CW-1:CW]),
        .z_start    (in_data_reg[2*CW+DW-1:2*CW]),
        .x_end      (in_data_reg[3*CW+DW-1:2*CW+DW]),
        .y_end      (in_data_reg[4*CW+DW-1:3*CW+DW]),
        .z_end      (in_data_reg[4*CW+2*DW-1:4*CW+DW]),
        .line_rgb   (in_data_reg[lps_pkg::IN_FIELDS_W-1:4*CW+2*DW]),
        .init_state (init_state)
    );

    assign base_state = (in_mode_reg == lps_pkg::MODE_START) ? init_state : state_reg;
    assign produce = (in_mode_reg == lps_pkg::MODE_START) || state_reg.active;

    lps_step u_step (
        .cur_state  (base_state),
        .pixel      (step_pixel),
        .last       (step_last),
        .next_state (stepped_state)
    );

    always_comb begin
        if (produce) begin
            state_next = stepped_state;
            res_pixel = step_pixel;
            res_last = step_last;
        end else begin
            state_next = state_reg;
            res_pixel = '0;
            res_last = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (work) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (work) begin
            out_res_reg <= produce;
            out_last_reg <= res_last;
            out_pixel_reg <= res_pixel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_res_reg;
    assign m_tlast = out_last_reg;
    assign m_tdata = lps_pkg::OUT_DATA_W'({out_pixel_reg.rgb, out_pixel_reg.z,
                                           out_pixel_reg.y, out_pixel_reg.x});

endmodule

### hdl/lps_checker.sv
// Port-level checker for the line pixel stepper and its bind to the top level.
`timescale 1ns / 1ps

module lps_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lps_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lps_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // The end point flag only comes with a produced pixel.
    a_last_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last flag without a pixel");

    // A next command without an active line gives an all-zero result.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("empty result carries data");

    // After reset no result is pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind line_pixel_stepper_top lps_checker u_lps_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the line pixel stepper: directed table, then random line walks.
`timescale 1ns / 1ps

module testbench;
    import lps_pkg::*;

    localparam int NDIR = 24;
    localparam int RAND_PER_PHASE = 509;
    localparam int STALL_LIMIT = 2000;
    localparam int CMIN = -(1 << (COORD_W - 1));
    localparam int CMAX = (1 << (COORD_W - 1)) - 1;

    typedef struct packed {
        logic                       drawn;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [DEPTH_W-1:0]         z;
        logic [RGB_W-1:0]           rgb;
        logic                       last;
    } pix_res_t;

    typedef struct {
        logic               mode;
        int                 xs;
        int                 ys;
        logic [DEPTH_W-1:0] zs;
        int                 xe;
        int                 ye;
        logic [DEPTH_W-1:0] ze;
        logic [RGB_W-1:0]   rgb;
        bit                 typed;
        pix_res_t           res;
    } dir_row_t;

    typedef struct {
        bit       typed;
        pix_res_t res;
    } typed_note_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // Copy of the line state used to predict each pixel.
    logic                       ln_active;
    logic signed [COORD_W-1:0]  ln_x;
    logic signed [COORD_W-1:0]  ln_y;
    logic signed [ERR_W-1:0]    ln_err;
    logic [DIST_W-1:0]          ln_steps;
    logic signed [COORD_W-1:0]  ln_tx;
    logic signed [COORD_W-1:0]  ln_ty;
    logic [DEPTH_W-1:0]         ln_depth;
    logic [RGB_W-1:0]           ln_rgb;
    logic                       ln_wide;
    logic                       ln_rising;
    logic signed [ERR_W-1:0]    ln_diag_inc;
    logic signed [ERR_W-1:0]    ln_flat_inc;
    logic signed [1:0]          ln_ystep;

    pix_res_t    pixel_q [$];
    typed_note_t typed_q [$];
    int          bad_pixels = 0;
    int          stall_cycles = 0;
    int          items_sent = 0;
    int          tx_idle = 19;
    int          rx_idle = 65;
    int          ph;

    dir_row_t plan [NDIR] = '{
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0,
          1'b1, '{1'b0, 12'h0, 12'h0, 32'h0, 24'h0, 1'b0}},
        '{MODE_START,     5,     7, 32'h1234_5678, 5,     7, 32'h9ABC_DEF0, 24'hFFFFFF,
          1'b1, '{1'b1, 12'h005, 12'h007, 32'h1234_5678, 24'hFFFFFF, 1'b1}},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0,
          1'b1, '{1'b0, 12'h0, 12'h0, 32'h0, 24'h0, 1'b0}},
        '{MODE_START, CMIN,  CMIN, 32'h8000_0000, CMAX,  CMAX, 32'h7FFF_FFFF, 24'h000000,
          1'b1, '{1'b1, 12'h800, 12'h800, 32'h8000_0000, 24'h000000, 1'b0}},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_START, CMAX,  CMIN, 32'h0000_0000, CMIN,  CMAX, 32'hFFFF_FFFF, 24'hA5A5A5,
          1'b1, '{1'b1, 12'h800, 12'h7FF, 32'hFFFF_FFFF, 24'hA5A5A5, 1'b0}},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_START,    10,     0, 32'h0001_8000, 13,    0, 32'h7FFF_0000, 24'h00FF00,
          1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_START,    -3,     4, 32'h0003_0000, -3,    1, 32'h0005_0000, 24'h123456,
          1'b1, '{1'b1, 12'hFFD, 12'h004, 32'h0003_0000, 24'h123456, 1'b0}},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_START,     0,     0, 32'h0000_1000, 5,     2, 32'h0000_2000, 24'hFF0000,
          1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_START,     0,     3, 32'h0000_3000, 1,    -2, 32'h0000_4000, 24'h0000FF,
          1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_START,     0,     1, 32'h0000_5000, 4,    -1, 32'h0000_6000, 24'h808080,
          1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0},
        '{MODE_START,     7,     7, 32'h0000_7000, 9,    12, 32'h0000_8000, 24'h7F7F7F,
          1'b0, '0},
        '{MODE_NEXT,      0,     0, 32'h0,         0,     0, 32'h0,         24'h0, 1'b0, '0}
    };

    line_pixel_stepper_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic pix_res_t next_pixel();
        pix_res_t r;
        logic     go_diag;
        r = '0;
        r.drawn = 1'b1;
        r.z = ln_depth;
        r.rgb = ln_rgb;
        if (ln_steps == 0) begin
            r.x = ln_tx;
            r.y = ln_ty;
            r.last = 1'b1;
            ln_active = 1'b0;
            return r;
        end
        r.x = ln_x;
        r.y = ln_y;
        if (ln_wide) begin
            go_diag = ln_rising ? (ln_err > 0) : (ln_err < 0);
        end else begin
            go_diag = ln_rising ? (ln_err < 0) : (ln_err > 0);
        end
        if (go_diag) begin
            ln_x = ln_x + COORD_W'(1);
            ln_y = ln_y + ln_ystep;
            ln_err = ln_err + ln_diag_inc;
        end else begin
            if (ln_wide) begin
                ln_x = ln_x + COORD_W'(1);
            end else begin
                ln_y = ln_y + ln_ystep;
            end
            ln_err = ln_err + ln_flat_inc;
        end
        ln_steps = ln_steps - DIST_W'(1);
        return r;
    endfunction

    function automatic pix_res_t step_line(logic mode, logic [IN_DATA_W-1:0] d);
        logic [COORD_W-1:0] xs_r, ys_r, xe_r, ye_r;
        logic [DEPTH_W-1:0] zs, ze;
        logic [RGB_W-1:0]   rgb;
        int                 xa, ya, xb, yb, t, dx, dy, ady;
        {rgb, ze, ye_r, xe_r, zs, ys_r, xs_r} = d[IN_FIELDS_W-1:0];
        if (mode == MODE_START) begin
            xa = int'($signed(xs_r));
            ya = int'($signed(ys_r));
            xb = int'($signed(xe_r));
            yb = int'($signed(ye_r));
            if (xa > xb) begin
                t = xa; xa = xb; xb = t;
                t = ya; ya = yb; yb = t;
                zs = ze;
            end
            dx = xb - xa;
            dy = yb - ya;
            ady = (dy < 0) ? -dy : dy;
            ln_x = COORD_W'(xa);
            ln_y = COORD_W'(ya);
            ln_tx = COORD_W'(xb);
            ln_ty = COORD_W'(yb);
            ln_depth = zs;
            ln_rgb = rgb;
            ln_rising = (dy > 0);
            ln_ystep = ln_rising ? 2'sd1 : -2'sd1;
            ln_wide = (dx >= ady);
            if (ln_wide) begin
                ln_steps = DIST_W'(dx);
                ln_flat_inc = ERR_W'(2 * dy);
                ln_err = ERR_W'(ln_rising ? (2 * dy - dx) : (2 * dy + dx));
                ln_diag_inc = ERR_W'(ln_rising ? (2 * dy - 2 * dx) : (2 * dy + 2 * dx));
            end else begin
                ln_steps = DIST_W'(ady);
                ln_err = ERR_W'(ln_rising ? (dy - 2 * dx) : (dy + 2 * dx));
                ln_diag_inc = ERR_W'(ln_rising ? (2 * dy - 2 * dx) : (2 * dy + 2 * dx));
                ln_flat_inc = ERR_W'(ln_rising ? (-2 * dx) : (2 * dx));
            end
            ln_active = 1'b1;
            return next_pixel();
        end
        if (!ln_active) begin
            return '0;
        end
        return next_pixel();
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_cmd(int xs, int ys, logic [DEPTH_W-1:0] zs,
                                                      int xe, int ye, logic [DEPTH_W-1:0] ze,
                                                      logic [RGB_W-1:0] rgb);
        return {rgb, ze, COORD_W'(ye), COORD_W'(xe), zs, COORD_W'(ys), COORD_W'(xs)};
    endfunction

    function automatic logic [IN_DATA_W-1:0] noise_bits();
        logic [IN_DATA_W-1:0] v;
        int                   i;
        v = '0;
        for (i = 0; i < IN_DATA_W; i += 32) begin
            v = (v << 32) | IN_DATA_W'($urandom);
        end
        return v;
    endfunction

    function automatic int rand_coord();
        logic [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        return int'($signed(v));
    endfunction

    function automatic int fold(int base, int delta);
        if (base + delta > CMAX || base + delta < CMIN) begin
            return base - delta;
        end
        return base + delta;
    endfunction

    task automatic send(logic mode, logic [IN_DATA_W-1:0] data, bit typed, pix_res_t res);
        typed_note_t n;
        n.typed = typed;
        n.res = res;
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        typed_q.push_back(n);
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        items_sent++;
    endtask

    task automatic random_line();
        int xs, ys, xe, ye, ddx, ddy, span, steps, n, pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            span = ($urandom_range(9) == 0) ? 200 : 12;
            xs = rand_coord();
            ys = rand_coord();
            ddx = $urandom_range(2 * span) - span;
            ddy = $urandom_range(2 * span) - span;
            case ($urandom_range(5))
                0: ddy = 0;
                1: ddx = 0;
                2: ddy = $urandom_range(1) ? ddx : -ddx;
                3: begin
                    ddx = 0;
                    ddy = 0;
                end
                default: ;
            endcase
            xe = fold(xs, ddx);
            ye = fold(ys, ddy);
            ddx = (xe > xs) ? xe - xs : xs - xe;
            ddy = (ye > ys) ? ye - ys : ys - ye;
            steps = (ddx > ddy) ? ddx : ddy;
            send(MODE_START, pack_cmd(xs, ys, $urandom, xe, ye, $urandom, RGB_W'($urandom)),
                 1'b0, '0);
            if ($urandom_range(4) == 0) begin
                n = $urandom_range(steps);
            end else begin
                n = steps + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
            end
            repeat (n) send(MODE_NEXT, noise_bits(), 1'b0, '0);
        end else if (pick < 90) begin
            send(MODE_START, noise_bits(), 1'b0, '0);
            repeat ($urandom_range(6)) send(MODE_NEXT, noise_bits(), 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 3)) send(MODE_NEXT, noise_bits(), 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge aclk) begin
        pix_res_t    got, want;
        typed_note_t note;
        if (aresetn) begin
            stall_cycles++;
            if (m_tvalid && m_tready) begin
                stall_cycles = 0;
                {got.rgb, got.z, got.y, got.x} = m_tdata[OUT_FIELDS_W-1:0];
                got.drawn = m_tuser;
                got.last = m_tlast;
                if (pixel_q.size() == 0) begin
                    bad_pixels++;
                    if (bad_pixels <= 10) begin
                        $display("unexpected result transaction: drawn=%0d x=%0d y=%0d",
                                 got.drawn, got.x, got.y);
                    end
                end else begin
                    want = pixel_q.pop_front();
                    if (got.drawn !== want.drawn || got.x !== want.x || got.y !== want.y ||
                        got.z !== want.z || got.rgb !== want.rgb || got.last !== want.last)
                    begin
                        bad_pixels++;
                        if (bad_pixels <= 10) begin
                            $display("expected drawn=%0d x=%0d y=%0d z=%h rgb=%h last=%0d",
                                     want.drawn, want.x, want.y, want.z, want.rgb, want.last);
                            $display("     got drawn=%0d x=%0d y=%0d z=%h rgb=%h last=%0d",
                                     got.drawn, got.x, got.y, got.z, got.rgb, got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                stall_cycles = 0;
                want = step_line(s_tuser, s_tdata);
                note = typed_q.pop_front();
                pixel_q.push_back(note.typed ? note.res : want);
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        ln_active = 1'b0;
        ln_x = '0;
        ln_y = '0;
        ln_err = '0;
        ln_steps = '0;
        ln_tx = '0;
        ln_ty = '0;
        ln_depth = '0;
        ln_rgb = '0;
        ln_wide = 1'b0;
        ln_rising = 1'b0;
        ln_diag_inc = '0;
        ln_flat_inc = '0;
        ln_ystep = '0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= MODE_START;
        m_tready <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NDIR; i++) begin
            send(plan[i].mode,
                 pack_cmd(plan[i].xs, plan[i].ys, plan[i].zs, plan[i].xe, plan[i].ye,
                          plan[i].ze, plan[i].rgb),
                 plan[i].typed, plan[i].res);
        end

        for (ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 19 : (ph == 1) ? 65 : 0;
            rx_idle = (ph == 0) ? 65 : (ph == 1) ? 19 : 0;
            while (items_sent < NDIR + (ph + 1) * RAND_PER_PHASE) begin
                random_line();
            end
            // Hold off new transactions until every pending pixel has drained.
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (pixel_q.size() != 0);
        end

        repeat (8) @(posedge aclk);
        if (bad_pixels == 0 && pixel_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
